// ===== design/avr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_pkg
// Types, constants and the arctangent table of the axis-angle rotation core.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int CW       = 32;
  localparam int AW       = 16;
  localparam int ANG_W    = 24;
  localparam int NSTG     = 20;
  localparam int STG_W    = 5;
  localparam int XY_W     = 34;
  localparam int Z_W      = 25;
  localparam int TRIG_W   = 28;
  localparam int D16_W    = 36;
  localparam int C16_W    = 35;
  localparam int P_W      = 38;
  localparam int LAT      = NSTG + 5;
  localparam int DLY      = NSTG;

  localparam logic signed [XY_W-1:0] CORDIC_INIT = XY_W'(652032874);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_t;

  typedef struct packed {
    logic signed [2:0][CW-1:0]    v;
    logic signed [2:0][C16_W-1:0] c16;
    logic signed [2:0][P_W-1:0]   p;
  } vec_t;

  function automatic logic signed [Z_W-1:0] atan_val(input logic [STG_W-1:0] i);
    logic signed [Z_W-1:0] t;
    case (i)
      5'd0:  t = Z_W'(2949120);
      5'd1:  t = Z_W'(1740967);
      5'd2:  t = Z_W'(919879);
      5'd3:  t = Z_W'(466945);
      5'd4:  t = Z_W'(234379);
      5'd5:  t = Z_W'(117304);
      5'd6:  t = Z_W'(58666);
      5'd7:  t = Z_W'(29335);
      5'd8:  t = Z_W'(14668);
      5'd9:  t = Z_W'(7334);
      5'd10: t = Z_W'(3667);
      5'd11: t = Z_W'(1833);
      5'd12: t = Z_W'(917);
      5'd13: t = Z_W'(458);
      5'd14: t = Z_W'(229);
      5'd15: t = Z_W'(115);
      5'd16: t = Z_W'(57);
      5'd17: t = Z_W'(29);
      5'd18: t = Z_W'(14);
      5'd19: t = Z_W'(7);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/avr_angle_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_angle_reduce
// Two-stage reduction of the angle into [-90, +90] degrees, CORDIC seed.
// ----------------------------------------------------------------------------
module avr_angle_reduce
  import avr_pkg::*;
(
  input  logic                    clk,
  input  logic signed [ANG_W-1:0] angle,
  output cordic_t                 seed
);

  localparam logic [24:0] OFFSET = 25'd8478720;
  localparam logic [10:0] RECIP  = 11'd1457;

  logic [24:0] n;
  logic [7:0]  q;
  logic [24:0] n_next;
  logic [24:0] mq;
  logic signed [25:0] r_raw;
  logic signed [25:0] r;
  logic signed [25:0] rr;
  logic               flip_next;

  always_comb begin
    n_next = 25'($signed({angle[ANG_W-1], angle})) + OFFSET;
    mq     = 25'(n_next[24:11]) * 25'(RECIP);
  end

  always_ff @(posedge clk) begin
    n <= n_next;
    q <= mq[23:16];
  end

  always_comb begin
    r_raw = $signed({1'b0, n}) - $signed(26'(q) * 26'd92160);
    r     = (r_raw < 0) ? r_raw + 26'sd92160 : r_raw;
    flip_next = 1'b0;
    rr = r;
    if (r > 26'sd23040 && r <= 26'sd69120) begin
      rr = r - 26'sd46080;
      flip_next = 1'b1;
    end else if (r > 26'sd69120) begin
      rr = r - 26'sd92160;
    end
  end

  always_ff @(posedge clk) begin
    seed.x    <= CORDIC_INIT;
    seed.y    <= '0;
    seed.z    <= Z_W'(rr <<< 8);
    seed.flip <= flip_next;
  end

endmodule

// ===== design/avr_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_cordic_cell
// One CORDIC rotation step; the stage index selects shift and arctangent.
// ----------------------------------------------------------------------------
module avr_cordic_cell
  import avr_pkg::*;
(
  input  logic             clk,
  input  logic [STG_W-1:0] stage,
  input  cordic_t          d,
  output cordic_t          q
);

  cordic_t q_next;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  always_comb begin
    dx = d.x >>> stage;
    dy = d.y >>> stage;
    q_next.flip = d.flip;
    if (!d.z[Z_W-1]) begin
      q_next.x = d.x - dy;
      q_next.y = d.y + dx;
      q_next.z = d.z - atan_val(stage);
    end else begin
      q_next.x = d.x + dy;
      q_next.y = d.y - dx;
      q_next.z = d.z + atan_val(stage);
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== design/avr_vec_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_vec_prep
// Three-stage pipeline: axis-vector products, rounded dot and cross, u*d16.
// ----------------------------------------------------------------------------
module avr_vec_prep
  import avr_pkg::*;
(
  input  logic                 clk,
  input  logic signed [CW-1:0] vx,
  input  logic signed [CW-1:0] vy,
  input  logic signed [CW-1:0] vz,
  input  logic signed [AW-1:0] ux,
  input  logic signed [AW-1:0] uy,
  input  logic signed [AW-1:0] uz,
  output vec_t                 q
);

  localparam int PR_W = CW + AW;

  logic signed [2:0][CW-1:0]         v1;
  logic signed [2:0][AW-1:0]         u1;
  logic signed [2:0][2:0][PR_W-1:0]  pr;
  logic signed [2:0][CW-1:0]         v2;
  logic signed [2:0][AW-1:0]         u2;
  logic signed [D16_W-1:0]           d16;
  logic signed [2:0][C16_W-1:0]      c16;
  logic signed [PR_W+1:0]            dot;
  logic signed [2:0][PR_W:0]         cr;
  logic signed [PR_W+1:0]            dot_r;
  logic signed [2:0][PR_W:0]         cr_r;
  logic signed [D16_W+AW-1:0]        up;
  logic signed [2:0][P_W-1:0]        p_next;

  always_ff @(posedge clk) begin
    v1 <= {vz, vy, vx};
    u1 <= {uz, uy, ux};
    pr[0][0] <= PR_W'(ux) * PR_W'(vx);
    pr[0][1] <= PR_W'(ux) * PR_W'(vy);
    pr[0][2] <= PR_W'(ux) * PR_W'(vz);
    pr[1][0] <= PR_W'(uy) * PR_W'(vx);
    pr[1][1] <= PR_W'(uy) * PR_W'(vy);
    pr[1][2] <= PR_W'(uy) * PR_W'(vz);
    pr[2][0] <= PR_W'(uz) * PR_W'(vx);
    pr[2][1] <= PR_W'(uz) * PR_W'(vy);
    pr[2][2] <= PR_W'(uz) * PR_W'(vz);
  end

  always_comb begin
    dot   = (PR_W+2)'($signed(pr[0][0])) + (PR_W+2)'($signed(pr[1][1])) +
            (PR_W+2)'($signed(pr[2][2]));
    cr[0] = (PR_W+1)'($signed(pr[1][2])) - (PR_W+1)'($signed(pr[2][1]));
    cr[1] = (PR_W+1)'($signed(pr[2][0])) - (PR_W+1)'($signed(pr[0][2]));
    cr[2] = (PR_W+1)'($signed(pr[0][1])) - (PR_W+1)'($signed(pr[1][0]));
    dot_r = (dot + (PR_W+2)'(8192)) >>> 14;
    for (int k = 0; k < 3; k++) begin
      cr_r[k] = ($signed(cr[k]) + (PR_W+1)'(8192)) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    v2  <= v1;
    u2  <= u1;
    d16 <= D16_W'(dot_r);
    for (int k = 0; k < 3; k++) begin
      c16[k] <= C16_W'(cr_r[k]);
    end
  end

  always_comb begin
    up = '0;
    for (int k = 0; k < 3; k++) begin
      up = (D16_W+AW)'($signed(u2[k])) * (D16_W+AW)'(d16);
      p_next[k] = P_W'((up + (D16_W+AW)'(8192)) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    q.v   <= v2;
    q.c16 <= c16;
    q.p   <= p_next;
  end

endmodule

// ===== design/avr_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_combine
// Weighted sum of the three Rodrigues terms, rounding and saturation.
// ----------------------------------------------------------------------------
module avr_combine
  import avr_pkg::*;
(
  input  logic                     clk,
  input  vec_t                     d,
  input  logic signed [TRIG_W-1:0] c,
  input  logic signed [TRIG_W-1:0] s,
  output logic signed [CW-1:0]     rx,
  output logic signed [CW-1:0]     ry,
  output logic signed [CW-1:0]     rz,
  output logic                     sat
);

  localparam int M1_W  = CW + TRIG_W;
  localparam int M2_W  = C16_W + TRIG_W;
  localparam int M3_W  = P_W + TRIG_W + 1;
  localparam int ACC_W = M3_W + 2;
  localparam int R_W   = ACC_W - 24;

  logic signed [TRIG_W:0]            omc;
  logic signed [2:0][M1_W-1:0]       m1;
  logic signed [2:0][M2_W-1:0]       m2;
  logic signed [2:0][M3_W-1:0]       m3;
  logic signed [ACC_W-1:0]           acc;
  logic signed [R_W-1:0]             r;
  logic signed [2:0][CW-1:0]         res;
  logic [2:0]                        clip;

  localparam logic signed [R_W-1:0] HI = R_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [R_W-1:0] LO = -HI - R_W'(1);

  assign omc = (TRIG_W+1)'(26'sh1000000) - (TRIG_W+1)'(c);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m1[k] <= M1_W'($signed(d.v[k])) * M1_W'(c);
      m2[k] <= M2_W'($signed(d.c16[k])) * M2_W'(s);
      m3[k] <= M3_W'($signed(d.p[k])) * M3_W'(omc);
    end
  end

  always_comb begin
    acc = '0;
    r   = '0;
    for (int k = 0; k < 3; k++) begin
      acc = ACC_W'($signed(m1[k])) + ACC_W'($signed(m2[k])) + ACC_W'($signed(m3[k])) +
            ACC_W'(25'sh0800000);
      r   = R_W'(acc >>> 24);
      clip[k] = (r > HI) || (r < LO);
      if (r > HI) begin
        res[k] = CW'(HI);
      end else if (r < LO) begin
        res[k] = CW'(LO);
      end else begin
        res[k] = CW'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    rx  <= res[0];
    ry  <= res[1];
    rz  <= res[2];
    sat <= |clip;
  end

endmodule

// ===== design/axis_angle_vector_rotation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_core
// Rodrigues rotation of a Q16.16 vector about a Q1.14 axis by a given angle.
//
//   channel  | handshake       | fields
//   ---------+-----------------+------------------------------------------
//   command  | start / busy    | vec_x/y/z, axis_x/y/z, angle_deg
//   result   | done (strobe)   | rot_x/y/z, saturated
//
// One beat per cycle; busy stays low. From accept to done a command passes
// the angle reduction, twenty CORDIC cells, the trig rounding register and
// the final multiply and sum. Reset clears the valid line only.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_core
  import avr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CW-1:0]    vec_x,
  input  logic signed [CW-1:0]    vec_y,
  input  logic signed [CW-1:0]    vec_z,
  input  logic signed [AW-1:0]    axis_x,
  input  logic signed [AW-1:0]    axis_y,
  input  logic signed [AW-1:0]    axis_z,
  input  logic signed [ANG_W-1:0] angle_deg,
  output logic                    done,
  output logic signed [CW-1:0]    rot_x,
  output logic signed [CW-1:0]    rot_y,
  output logic signed [CW-1:0]    rot_z,
  output logic                    saturated
);

  cordic_t                  chain [0:NSTG];
  vec_t                     vq;
  vec_t                     dly [0:DLY-1];
  logic [LAT-1:0]           vld;
  logic signed [XY_W-1:0]   cx;
  logic signed [XY_W-1:0]   sy;
  logic signed [TRIG_W-1:0] cs;
  logic signed [TRIG_W-1:0] sn;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  avr_angle_reduce u_red (
    .clk   (clk),
    .angle (angle_deg),
    .seed  (chain[0])
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk   (clk),
      .stage (STG_W'(i)),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  assign cx = (chain[NSTG].x + XY_W'(32)) >>> 6;
  assign sy = (chain[NSTG].y + XY_W'(32)) >>> 6;

  always_ff @(posedge clk) begin
    cs <= chain[NSTG].flip ? -TRIG_W'(cx) : TRIG_W'(cx);
    sn <= chain[NSTG].flip ? -TRIG_W'(sy) : TRIG_W'(sy);
  end

  avr_vec_prep u_prep (
    .clk (clk),
    .vx  (vec_x),
    .vy  (vec_y),
    .vz  (vec_z),
    .ux  (axis_x),
    .uy  (axis_y),
    .uz  (axis_z),
    .q   (vq)
  );

  always_ff @(posedge clk) begin
    dly[0] <= vq;
    for (int k = 1; k < DLY; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  avr_combine u_comb (
    .clk (clk),
    .d   (dly[DLY-1]),
    .c   (cs),
    .s   (sn),
    .rx  (rot_x),
    .ry  (rot_y),
    .rz  (rot_z),
    .sat (saturated)
  );

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching command");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (rot_x == MAXV || rot_x == MINV || rot_y == MAXV ||
                             rot_y == MINV || rot_z == MAXV || rot_z == MINV))
    else $error("saturated flag without clipped component");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT-2] && !vld[LAT-3]) |=> (done && !vld[LAT-2]) || vld[LAT-2])
    else $error("valid line lost a beat");

endmodule

// ===== verif/avr_rotation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_rotation_checker
// Watches the command and result channels of the rotation core. For every
// accepted command beat it computes the rotated vector with its own fixed-point
// Rodrigues model, queues it, and compares every done beat field by field.
// ----------------------------------------------------------------------------
module avr_rotation_checker
  import avr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [CW-1:0]    vec_x,
  input  logic signed [CW-1:0]    vec_y,
  input  logic signed [CW-1:0]    vec_z,
  input  logic signed [AW-1:0]    axis_x,
  input  logic signed [AW-1:0]    axis_y,
  input  logic signed [AW-1:0]    axis_z,
  input  logic signed [ANG_W-1:0] angle_deg,
  input  logic                    done,
  input  logic signed [CW-1:0]    rot_x,
  input  logic signed [CW-1:0]    rot_y,
  input  logic signed [CW-1:0]    rot_z,
  input  logic                    saturated,
  output int                      errors,
  output int                      pending,
  output int                      rotations_checked,
  output int                      clipped_seen
);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 sat;
  } rotation_t;

  localparam longint TURN = 92160;
  localparam longint QTR  = 23040;

  longint atan_deg16 [NSTG] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  rotation_t rotated_q[$];

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic void trig(input longint ang, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = ang % TURN;
    flip = 0;
    if (r < 0) r += TURN;
    if (r > QTR && r <= 3 * QTR) begin
      r -= 2 * QTR;
      flip = 1;
    end else if (r > 3 * QTR) begin
      r -= TURN;
    end
    x = 652032874;
    y = 0;
    z = r * 256;
    for (int i = 0; i < NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg16[i];
      end else begin
        x += dx; y -= dy; z += atan_deg16[i];
      end
    end
    c = round_shift(x, 6);
    s = round_shift(y, 6);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic rotation_t rodrigues(
    longint vx, longint vy, longint vz, longint ux, longint uy, longint uz, longint ang
  );
    longint    v [3], u [3], cr [3], res [3];
    longint    s, c, dot, d16, c16, p, acc, r;
    longint    hi, lo;
    rotation_t o;
    v = '{vx, vy, vz};
    u = '{ux, uy, uz};
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    trig(ang, s, c);
    dot = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    d16 = round_shift(dot, 14);
    o.sat = 0;
    for (int k = 0; k < 3; k++) begin
      c16 = round_shift(cr[k], 14);
      p = round_shift(u[k] * d16, 14);
      acc = v[k] * c + c16 * s + p * ((longint'(1) <<< 24) - c);
      r = round_shift(acc, 24);
      if (r > hi) begin
        r = hi; o.sat = 1;
      end else if (r < lo) begin
        r = lo; o.sat = 1;
      end
      res[k] = r;
    end
    o.x = res[0][CW-1:0];
    o.y = res[1][CW-1:0];
    o.z = res[2][CW-1:0];
    return o;
  endfunction

  initial begin
    errors = 0;
    rotations_checked = 0;
    clipped_seen = 0;
  end

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    rotation_t exp_rot;
    if (!rst) begin
      if (start && !busy)
        rotated_q.push_back(rodrigues(vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg));
      if (done) begin
        if (rotated_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: result beat with nothing expected at %0t", $time);
        end else begin
          exp_rot = rotated_q.pop_front();
          rotations_checked++;
          if (exp_rot.sat) clipped_seen++;
          if (rot_x !== exp_rot.x || rot_y !== exp_rot.y || rot_z !== exp_rot.z ||
              saturated !== exp_rot.sat) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: beat %0d exp (%0d %0d %0d sat %0b) got (%0d %0d %0d sat %0b)",
                       rotations_checked, exp_rot.x, exp_rot.y, exp_rot.z, exp_rot.sat,
                       rot_x, rot_y, rot_z, saturated);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_axis_angle_vector_rotation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotation_core
// Drives directed and random rotation commands with random idle cycles into
// the core; the checker predicts and compares each result beat.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotation_core;
  import avr_pkg::*;

  localparam int ONE_Q14 = 16384;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [CW-1:0]    vec_x, vec_y, vec_z;
  logic signed [AW-1:0]    axis_x, axis_y, axis_z;
  logic signed [ANG_W-1:0] angle_deg;
  logic                    done;
  logic signed [CW-1:0]    rot_x, rot_y, rot_z;
  logic                    saturated;
  int                      errors, pending, rotations_checked, clipped_seen;
  int                      wait_cycles;

  axis_angle_vector_rotation_core u_dut (.*);

  avr_rotation_checker u_chk (.*);

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    #4_000_000;
    $display("axis_angle_vector_rotation_core test failed");
    $finish;
  end

  task automatic send_rotation(
    logic signed [CW-1:0] vx, logic signed [CW-1:0] vy, logic signed [CW-1:0] vz,
    logic signed [AW-1:0] ux, logic signed [AW-1:0] uy, logic signed [AW-1:0] uz,
    logic signed [ANG_W-1:0] ang, bit may_idle
  );
    if (may_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    vec_x     <= vx;
    vec_y     <= vy;
    vec_z     <= vz;
    axis_x    <= ux;
    axis_y    <= uy;
    axis_z    <= uz;
    angle_deg <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [AW-1:0] unit_ish();
    return AW'($signed($urandom_range(2 * ONE_Q14)) - ONE_Q14);
  endfunction

  initial begin
    int sel;
    start = 0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    axis_x = 0; axis_y = 0; axis_z = 0;
    angle_deg = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: angle quadrants, zero and extreme axes, saturating vectors
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, 0, 0);
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, 90 * 256, 0);
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, 180 * 256, 0);
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, 270 * 256, 0);
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, 360 * 256, 0);
    send_rotation(32'h0001_0000, 0, 0, 0, 0, ONE_Q14, -90 * 256, 0);
    send_rotation(0, 32'h0002_0000, 0, ONE_Q14, 0, 0, 23041, 0);
    send_rotation(0, 32'h0002_0000, 0, ONE_Q14, 0, 0, 69121, 0);
    send_rotation(0, 0, 32'h0003_0000, 0, ONE_Q14, 0, 24'sh7FFFFF, 0);
    send_rotation(0, 0, 32'h0003_0000, 0, ONE_Q14, 0, 24'sh800000, 0);
    send_rotation(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 0, 0, 0, 45 * 256, 0);
    send_rotation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    send_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    send_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 180 * 256, 0);
    send_rotation(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 30 * 256, 0);
    send_rotation(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'sh8000, 16'sh8000, 16'sh8000, 120 * 256, 0);
    send_rotation(32'h4000_0000, 32'hC000_0000, 32'h2000_0000,
                  16'sh8000, 16'sh7FFF, 16'sh8000, -45 * 256, 0);
    send_rotation(32'hFFFF_FFFF, 1, 32'hFFFF_0000, 9000, 9000, 9000, 1, 0);
    send_rotation(32'h0005_8000, 32'hFFFA_8000, 32'h0001_0000, 11585, 11585, 0, -1, 0);
    send_rotation(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 2000, -3000, 31000, 46080, 0);

    for (int n = 0; n < 1550; n++) begin
      sel = $urandom_range(99);
      if (sel < 45)
        send_rotation($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000,
                      $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000,
                      $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000,
                      unit_ish(), unit_ish(), unit_ish(),
                      ANG_W'(int'($urandom_range(720 * 256)) - 360 * 256),
                      !(n >= 600 && n < 900));
      else if (sel < 80)
        send_rotation($urandom, $urandom, $urandom, AW'($urandom), AW'($urandom),
                      AW'($urandom), ANG_W'($urandom), !(n >= 600 && n < 900));
      else
        send_rotation($urandom, $urandom, $urandom, unit_ish(), unit_ish(), unit_ish(),
                      ANG_W'($urandom), !(n >= 600 && n < 900));
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LAT + 10) @(posedge clk);

    $display("Covered %0d rotations (%0d clipped) over all angle quadrants and axis extremes.",
             rotations_checked, clipped_seen);
    if (errors == 0 && pending == 0)
      $display("axis_angle_vector_rotation_core test passed");
    else
      $display("axis_angle_vector_rotation_core test failed");
    $finish;
  end

endmodule
